// ----- src/dta_pkg.sv -----
package dta_pkg;

  localparam int DATA_W  = 16;
  localparam int SENS_W  = 4;
  localparam int ACT_W   = 3;
  localparam int EVENT_W = 2;

  localparam int SKIP_SAMPLES = 4;
  localparam int AVERAGE_LOG2 = 3;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [DATA_W-1:0] MARGIN_RST      = 16'd10;
  localparam logic [SENS_W-1:0] SENSITIVITY_RST = 4'd2;
  localparam logic [DATA_W-1:0] TIMEOUT_RST     = 16'd60;

  localparam logic [ACT_W-1:0] ACT_SAMPLE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CALIBRATE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ARM       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DISARM    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_TICK      = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_CALIB = 2'd1,
    MODE_ARMED = 2'd2
  } mode_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NO_CALIB = 2'd0,
    EV_TIMEOUT  = 2'd1,
    EV_DONE     = 2'd2,
    EV_ALARM    = 2'd3
  } event_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] distance;
  } item_t;

  typedef struct packed {
    event_e            event_res;
    logic [DATA_W-1:0] reference;
  } result_t;

endpackage

// ----- src/distance_tripwire_alarm.sv -----
// Distance tripwire: takes samples, commands and ticks one transaction per clock
// cycle. Each transaction is held in an input register, its effect on mode, count,
// reference and tick timer is worked out combinationally, and any event goes to an
// output register, so a result is on the output once its transaction has passed the
// input register and then been loaded into the output register.
// Throughput is one transaction per cycle; the input side stalls only while an
// event-producing transaction waits for a full output register to be drained.
module distance_tripwire_alarm #(
  parameter int SkipSamples = dta_pkg::SKIP_SAMPLES,
  parameter int AverageLog2 = dta_pkg::AVERAGE_LOG2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dta_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dta_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // action[2:0], distance[18:3]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata   // event_res[1:0], reference[17:2]
);

  logic             in_valid_q;
  dta_pkg::item_t   in_item_q;
  logic             emit;
  logic             out_free;
  logic             advance;
  dta_pkg::result_t result;
  dta_pkg::result_t out_result;

  assign advance       = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.action   <= s_axis_tdata[2:0];
      in_item_q.distance <= s_axis_tdata[18:3];
    end
  end

  dta_core #(
    .SkipSamples (SkipSamples),
    .AverageLog2 (AverageLog2)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (in_item_q),
    .advance_i  (advance),
    .emit_o     (emit),
    .result_o   (result)
  );

  dta_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && emit),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {6'd0, out_result.reference, out_result.event_res};

endmodule

// ----- src/dta_core.sv -----
module dta_core #(
  parameter int SkipSamples = dta_pkg::SKIP_SAMPLES,
  parameter int AverageLog2 = dta_pkg::AVERAGE_LOG2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dta_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dta_pkg::DATA_W-1:0]     cfg_data_i,
  input  dta_pkg::item_t                 item_i,
  input  logic                           advance_i,
  output logic                           emit_o,
  output dta_pkg::result_t               result_o
);

  localparam int CntRaw = $clog2(SkipSamples + 2**AverageLog2 + 1);
  localparam int CntW   = (CntRaw > dta_pkg::SENS_W) ? CntRaw : dta_pkg::SENS_W;
  localparam int SumW   = dta_pkg::DATA_W + AverageLog2;

  localparam logic [CntW-1:0] CntSkip = CntW'(SkipSamples);
  localparam logic [CntW-1:0] CntDone = CntW'(SkipSamples + 2**AverageLog2);

  logic [dta_pkg::DATA_W-1:0] margin_q;
  logic [dta_pkg::SENS_W-1:0] sens_q;
  logic [dta_pkg::DATA_W-1:0] timeout_q;

  dta_pkg::mode_e             mode_q, mode_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [SumW-1:0]            sum_q, sum_d;
  logic [dta_pkg::DATA_W-1:0] ticks_q, ticks_d;

  logic [dta_pkg::DATA_W-1:0] ticks_inc;
  logic [CntW-1:0]            cnt_inc;
  logic [SumW-1:0]            sum_add;
  logic [dta_pkg::DATA_W-1:0] ref_cur;
  logic [CntW-1:0]            sens_ext;
  logic [CntW-1:0]            cnt_armed;
  logic                       is_short;
  dta_pkg::event_e            event_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q  <= dta_pkg::MARGIN_RST;
      sens_q    <= dta_pkg::SENSITIVITY_RST;
      timeout_q <= dta_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dta_pkg::CFG_MARGIN:      margin_q  <= cfg_data_i;
        dta_pkg::CFG_SENSITIVITY: sens_q    <= cfg_data_i[dta_pkg::SENS_W-1:0];
        dta_pkg::CFG_TIMEOUT:     timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= dta_pkg::MODE_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
      ticks_q <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      ticks_q <= ticks_d;
    end
  end

  assign ticks_inc = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;
  assign cnt_inc   = cnt_q + 1'b1;
  assign sum_add   = sum_q + SumW'(item_i.distance);
  assign ref_cur   = sum_q[dta_pkg::DATA_W-1:0];
  assign sens_ext  = CntW'(sens_q);
  // no sample is short when the reference does not exceed the margin
  assign is_short  = (ref_cur > margin_q) && (item_i.distance < (ref_cur - margin_q));
  assign cnt_armed = !is_short ? '0 : ((cnt_q >= sens_ext) ? sens_ext : cnt_inc);

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    ticks_d = ticks_q;
    emit_o  = 1'b0;
    event_d = dta_pkg::EV_ALARM;
    case (mode_q)
      dta_pkg::MODE_CALIB: begin
        if (item_i.action == dta_pkg::ACT_TICK) begin
          ticks_d = ticks_inc;
          if (ticks_inc >= timeout_q) begin
            mode_d  = dta_pkg::MODE_IDLE;
            cnt_d   = '0;
            sum_d   = '0;
            ticks_d = '0;
            emit_o  = 1'b1;
            event_d = dta_pkg::EV_TIMEOUT;
          end
        end else if (item_i.action != dta_pkg::ACT_SAMPLE) begin
          // any other item aborts calibration silently
          mode_d  = dta_pkg::MODE_IDLE;
          cnt_d   = '0;
          sum_d   = '0;
          ticks_d = '0;
        end else begin
          ticks_d = '0;
          cnt_d   = cnt_inc;
          if (cnt_inc > CntSkip) begin
            sum_d = sum_add;
            if (cnt_inc >= CntDone) begin
              sum_d   = sum_add >> AverageLog2;
              cnt_d   = '0;
              mode_d  = dta_pkg::MODE_IDLE;
              emit_o  = 1'b1;
              event_d = dta_pkg::EV_DONE;
            end
          end
        end
      end
      dta_pkg::MODE_ARMED: begin
        if (item_i.action == dta_pkg::ACT_SAMPLE) begin
          cnt_d = cnt_armed;
          if (cnt_armed >= sens_ext) begin
            emit_o  = 1'b1;
            event_d = dta_pkg::EV_ALARM;
          end
        end else if (item_i.action == dta_pkg::ACT_DISARM) begin
          mode_d = dta_pkg::MODE_IDLE;
        end else if (item_i.action == dta_pkg::ACT_CALIBRATE) begin
          mode_d  = dta_pkg::MODE_CALIB;
          cnt_d   = '0;
          sum_d   = '0;
          ticks_d = '0;
        end
      end
      default: begin
        mode_d = dta_pkg::MODE_IDLE;
        if (item_i.action == dta_pkg::ACT_CALIBRATE) begin
          mode_d  = dta_pkg::MODE_CALIB;
          cnt_d   = '0;
          sum_d   = '0;
          ticks_d = '0;
        end else if (item_i.action == dta_pkg::ACT_ARM) begin
          if (sum_q == '0) begin
            emit_o  = 1'b1;
            event_d = dta_pkg::EV_NO_CALIB;
          end else begin
            mode_d = dta_pkg::MODE_ARMED;
          end
        end
      end
    endcase
  end

  // whenever a result is produced, sum_d holds the averaged sum or zero, so the low bits are the reference
  assign result_o.event_res = event_d;
  assign result_o.reference = sum_d[dta_pkg::DATA_W-1:0];

endmodule

// ----- src/dta_out_stage.sv -----
module dta_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dta_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output dta_pkg::result_t result_o
);

  logic             valid_q;
  dta_pkg::result_t data_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule
